[rtl/core/json_string_utf8_sanitizer_assert.svh]
// Assertion macros for the JSON string UTF-8 sanitizer.
// Included by the RTL modules that carry assertions; depends on nothing else.
`ifndef JSON_STRING_UTF8_SANITIZER_ASSERT_SVH
`define JSON_STRING_UTF8_SANITIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define JSAN_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define JSAN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define JSAN_ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define JSAN_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[rtl/core/jsan_pkg.sv]
// Shared types and constants for the JSON string UTF-8 sanitizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package jsan_pkg;

   // ASCII codes used by the string tracker and the escape expander.
   localparam logic [7:0] BACKSLASH = 8'h5C;
   localparam logic [7:0] QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_U    = 8'h75;
   localparam logic [7:0] CHAR_0    = 8'h30;

   // UTF-8 lead byte masks and patterns.
   localparam logic [7:0] MASK_2 = 8'hE0;
   localparam logic [7:0] LEAD_2 = 8'hC0;
   localparam logic [7:0] MASK_3 = 8'hF0;
   localparam logic [7:0] LEAD_3 = 8'hE0;
   localparam logic [7:0] MASK_4 = 8'hF8;
   localparam logic [7:0] LEAD_4 = 8'hF0;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_PAT  = 8'h80;

   // One input byte can cause at most four output operations.
   localparam int MAX_OPS    = 4;
   localparam int OPS_CNT_W  = $clog2(MAX_OPS + 1);
   localparam int HELD_DEPTH = 3;

   // An escape is the six bytes backslash, u, 0, 0 and two hex digits.
   localparam int ESC_LEN  = 6;
   localparam int STEP_W   = $clog2(ESC_LEN);

   // Operation queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic {
      OP_PASS   = 1'b0,
      OP_ESCAPE = 1'b1
   } op_kind_type;

   // One operation: pass a byte, or expand it into an escape.
   typedef struct packed {
      op_kind_type kind;
      logic [7:0]  data;
      logic        replaced;
      logic        last;
   } op_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       any_replaced;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/json_string_utf8_sanitizer.sv]
// JSON string UTF-8 sanitizer. Bytes enter through a queue-style port (push/full)
// and leave through another (empty/pop). Plain bytes sustain one byte per cycle
// while the output is popped, passing the pending list, the queue, the current
// operation register and the output register. Each invalid byte inside a string
// becomes the six-byte escape \u00XX, which the output side sends byte by byte;
// a four-deep operation queue lets the input run ahead meanwhile. A single input
// byte can yield up to four operations (a broken held sequence plus the new
// byte), handed over by the front end one per cycle while the queue has room, so
// full stays high while more than one is pending, or one and the queue is full.
// Depends on jsan_pkg, jsan_front, jsan_queue and jsan_back.
`default_nettype none

module json_string_utf8_sanitizer (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  jsan_pkg::req_type req_data,
   output logic              empty,
   input  logic              pop,
   output jsan_pkg::rsp_type rsp_data
);
   import jsan_pkg::*;

   logic   fq_push;
   op_type fq_op;
   logic   fq_full;
   logic   qb_pop;
   logic   qb_empty;
   op_type qb_head;

   // Classification and operation building.
   jsan_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .q_push   (fq_push),
      .q_op     (fq_op),
      .q_full   (fq_full)
   );

   // Decoupling queue.
   jsan_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (fq_push),
      .push_op (fq_op),
      .full    (fq_full),
      .pop     (qb_pop),
      .empty   (qb_empty),
      .head_op (qb_head)
   );

   // Beat expansion and output register.
   jsan_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (qb_empty),
      .q_head   (qb_head),
      .q_pop    (qb_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/core/jsan_front.sv]
// Front end of the sanitizer: string tracking, UTF-8 sequence checks and
// expansion of each accepted byte into pass or escape operations. Uses jsan_pkg.
`default_nettype none
`include "json_string_utf8_sanitizer_assert.svh"

module jsan_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   output logic            full,
   input  jsan_pkg::req_type req_data,
   output logic            q_push,
   output jsan_pkg::op_type q_op,
   input  logic            q_full
);
   import jsan_pkg::*;

   // Sequence length from a lead byte; zero means an unknown lead.
   function automatic logic [2:0] seq_len(input logic [7:0] lead);
      logic [2:0] len;
      if (lead[7] == 1'b0) begin
         len = 3'd1;
      end else if ((lead & MASK_2) == LEAD_2) begin
         len = 3'd2;
      end else if ((lead & MASK_3) == LEAD_3) begin
         len = 3'd3;
      end else if ((lead & MASK_4) == LEAD_4) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

   function automatic op_type make_op(input op_kind_type kind, input logic [7:0] data,
                                      input logic rep);
      op_type op;
      op.kind     = kind;
      op.data     = data;
      op.replaced = rep;
      op.last     = 1'b0;
      return op;
   endfunction

   // Stream state.
   logic                 inside_ff, inside_in;
   logic                 after_bs_ff, after_bs_in;
   logic                 replaced_ff, replaced_in;
   logic [1:0]           held_cnt_ff, held_cnt_in;
   logic [7:0]           held_lead_ff, held_lead_in;
   logic [7:0]           held_tail_ff [HELD_DEPTH];
   logic [7:0]           held_tail_in [HELD_DEPTH];

   // Pending operations of this byte, drained one per cycle unless q_full.
   op_type               pend_ff [MAX_OPS];
   op_type               pend_in [MAX_OPS];
   logic [OPS_CNT_W-1:0] pend_cnt_ff, pend_cnt_in;

   logic                 accept;
   logic [OPS_CNT_W-1:0] new_cnt;

   // Operation handshake toward the queue and input backpressure.
   always_comb begin
      q_push = (pend_cnt_ff != '0) && !q_full;
      q_op   = pend_ff[0];
      full   = (pend_cnt_ff > OPS_CNT_W'(1)) || ((pend_cnt_ff == OPS_CNT_W'(1)) && q_full);
      accept = push && !full;
   end

   // Classify the incoming byte and build its list of operations in order.
   always_comb begin
      logic [7:0]           b;
      logic                 eob;
      logic                 fresh;
      logic [2:0]           kn;
      logic [2:0]           len;
      logic [OPS_CNT_W-1:0] n;
      logic [OPS_CNT_W-1:0] nm1;
      b            = req_data.data_byte;
      eob          = req_data.end_of_buffer;
      fresh        = 1'b0;
      n            = '0;
      nm1          = '0;
      len          = 3'd0;
      kn           = 3'd0;
      inside_in    = inside_ff;
      after_bs_in  = after_bs_ff;
      replaced_in  = replaced_ff;
      held_cnt_in  = held_cnt_ff;
      held_lead_in = held_lead_ff;
      held_tail_in = held_tail_ff;
      for (int i = 0; i < MAX_OPS; i++) begin
         pend_in[i] = '0;
      end

      if (held_cnt_ff != 2'd0) begin
         if ((b & CONT_MASK) == CONT_PAT) begin
            // Continuation byte: store it and check for a complete sequence.
            held_tail_in[held_cnt_ff - 2'd1] = b;
            kn = {1'b0, held_cnt_ff} + 3'd1;
            if (kn == seq_len(held_lead_ff)) begin
               pend_in[n[1:0]] = make_op(OP_PASS, held_lead_ff, replaced_in);
               n = n + 1'b1;
               for (int j = 0; j < HELD_DEPTH; j++) begin
                  if (2'(j) < held_cnt_ff) begin
                     pend_in[n[1:0]] = make_op(OP_PASS, held_tail_in[j], replaced_in);
                     n = n + 1'b1;
                  end
               end
               held_cnt_in = 2'd0;
            end else begin
               held_cnt_in = kn[1:0];
            end
         end else begin
            // Broken sequence: escape everything held, then treat the byte anew.
            replaced_in = 1'b1;
            pend_in[n[1:0]] = make_op(OP_ESCAPE, held_lead_ff, 1'b1);
            n = n + 1'b1;
            for (int j = 0; j < HELD_DEPTH - 1; j++) begin
               if (2'(j + 1) < held_cnt_ff) begin
                  pend_in[n[1:0]] = make_op(OP_ESCAPE, held_tail_ff[j], 1'b1);
                  n = n + 1'b1;
               end
            end
            held_cnt_in = 2'd0;
            fresh       = 1'b1;
         end
      end else begin
         fresh = 1'b1;
      end

      // A byte that does not continue a held sequence.
      if (fresh) begin
         if (!inside_ff) begin
            if (b == QUOTE) begin
               inside_in = 1'b1;
            end
            pend_in[n[1:0]] = make_op(OP_PASS, b, replaced_in);
            n = n + 1'b1;
         end else if (after_bs_ff) begin
            after_bs_in = 1'b0;
            pend_in[n[1:0]] = make_op(OP_PASS, b, replaced_in);
            n = n + 1'b1;
         end else if (b == BACKSLASH) begin
            after_bs_in = 1'b1;
            pend_in[n[1:0]] = make_op(OP_PASS, b, replaced_in);
            n = n + 1'b1;
         end else if (b == QUOTE) begin
            inside_in = 1'b0;
            pend_in[n[1:0]] = make_op(OP_PASS, b, replaced_in);
            n = n + 1'b1;
         end else begin
            len = seq_len(b);
            if (len == 3'd1) begin
               pend_in[n[1:0]] = make_op(OP_PASS, b, replaced_in);
               n = n + 1'b1;
            end else if (len == 3'd0) begin
               replaced_in = 1'b1;
               pend_in[n[1:0]] = make_op(OP_ESCAPE, b, 1'b1);
               n = n + 1'b1;
            end else begin
               held_lead_in = b;
               held_cnt_in  = 2'd1;
            end
         end
      end

      // End of buffer: flush what is still held, mark the last beat, restart.
      if (eob) begin
         if (held_cnt_in != 2'd0) begin
            replaced_in = 1'b1;
            pend_in[n[1:0]] = make_op(OP_ESCAPE, held_lead_in, 1'b1);
            n = n + 1'b1;
            for (int j = 0; j < HELD_DEPTH - 1; j++) begin
               if (2'(j + 1) < held_cnt_in) begin
                  pend_in[n[1:0]] = make_op(OP_ESCAPE, held_tail_in[j], 1'b1);
                  n = n + 1'b1;
               end
            end
            held_cnt_in = 2'd0;
         end
         nm1 = n - 1'b1;
         if (n != '0) begin
            pend_in[nm1[1:0]].last = 1'b1;
         end
         inside_in   = 1'b0;
         after_bs_in = 1'b0;
         replaced_in = 1'b0;
      end
      new_cnt = n;
   end

   // Next count of pending operations.
   always_comb begin
      if (accept) begin
         pend_cnt_in = new_cnt;
      end else if (q_push) begin
         pend_cnt_in = pend_cnt_ff - 1'b1;
      end else begin
         pend_cnt_in = pend_cnt_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         inside_ff   <= 1'b0;
         after_bs_ff <= 1'b0;
         replaced_ff <= 1'b0;
         held_cnt_ff <= 2'd0;
         pend_cnt_ff <= '0;
      end else begin
         pend_cnt_ff <= pend_cnt_in;
         if (accept) begin
            inside_ff   <= inside_in;
            after_bs_ff <= after_bs_in;
            replaced_ff <= replaced_in;
            held_cnt_ff <= held_cnt_in;
         end
      end
   end

   // Held bytes and the pending operation list.
   always_ff @(posedge clock) begin
      if (accept) begin
         held_lead_ff <= held_lead_in;
         held_tail_ff <= held_tail_in;
         pend_ff      <= pend_in;
      end else if (q_push) begin
         for (int i = 0; i < MAX_OPS - 1; i++) begin
            pend_ff[i] <= pend_ff[i + 1];
         end
      end
   end

   `JSAN_ASSERT_ALWAYS(a_pend_bound, clock, reset, pend_cnt_ff <= OPS_CNT_W'(MAX_OPS), "pending operation count exceeds the list size")

endmodule

`default_nettype wire

[rtl/core/jsan_queue.sv]
// Short operation queue that decouples the front end from the byte expander.
// Uses jsan_pkg for the operation type and depth.
`default_nettype none
`include "json_string_utf8_sanitizer_assert.svh"

module jsan_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  jsan_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output jsan_pkg::op_type head_op
);
   import jsan_pkg::*;

   op_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   // Status and head of the queue.
   always_comb begin
      full    = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
      empty   = (count_ff == '0);
      head_op = slot_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop  = pop && !empty;
   end

   // Pointer and count updates.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage slots.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   `JSAN_ASSERT_ALWAYS(a_no_push_full, clock, reset, !(push && full), "operation pushed into a full queue")
   `JSAN_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= (QPTR_W + 1)'(QUEUE_DEPTH), "queue count exceeds its depth")

endmodule

`default_nettype wire

[rtl/core/jsan_back.sv]
// Back end of the sanitizer: turns queued operations into output beats,
// expanding each escape into six bytes. Uses jsan_pkg.
`default_nettype none
`include "json_string_utf8_sanitizer_assert.svh"

module jsan_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  jsan_pkg::op_type q_head,
   output logic             q_pop,
   output logic             empty,
   input  logic             pop,
   output jsan_pkg::rsp_type rsp_data
);
   import jsan_pkg::*;

   // Uppercase hex digit for one nibble.
   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      logic [7:0] c;
      if (nib < 4'd10) begin
         c = CHAR_0 + {4'b0, nib};
      end else begin
         c = 8'h37 + {4'b0, nib};
      end
      return c;
   endfunction

   op_type            cur_ff;
   logic              cur_valid_ff, cur_valid_in;
   logic [STEP_W-1:0] step_ff, step_in;
   rsp_type           out_ff, out_in;
   logic              out_valid_ff, out_valid_in;

   logic              step_last;
   logic              out_free;
   logic              emit;
   logic              cur_done;
   logic [7:0]        beat_byte;

   // Handshake between the current operation, the queue and the output register.
   always_comb begin
      step_last = (cur_ff.kind == OP_PASS) || (step_ff == STEP_W'(ESC_LEN - 1));
      out_free  = !out_valid_ff || pop;
      emit      = cur_valid_ff && out_free;
      cur_done  = emit && step_last;
      q_pop     = !q_empty && (!cur_valid_ff || cur_done);
      empty     = !out_valid_ff;
      rsp_data  = out_ff;
   end

   // Byte of the current beat.
   always_comb begin
      beat_byte = cur_ff.data;
      if (cur_ff.kind == OP_ESCAPE) begin
         unique case (step_ff)
            STEP_W'(0): beat_byte = BACKSLASH;
            STEP_W'(1): beat_byte = CHAR_U;
            STEP_W'(2): beat_byte = CHAR_0;
            STEP_W'(3): beat_byte = CHAR_0;
            STEP_W'(4): beat_byte = hex_char(cur_ff.data[7:4]);
            STEP_W'(5): beat_byte = hex_char(cur_ff.data[3:0]);
            default:    beat_byte = CHAR_0;
         endcase
      end
      out_in.out_byte     = beat_byte;
      out_in.out_last     = cur_ff.last && step_last;
      out_in.any_replaced = cur_ff.replaced;
   end

   // Next state of the expander.
   always_comb begin
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         step_in      = '0;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
         step_in      = '0;
      end else if (emit) begin
         step_in = step_ff + 1'b1;
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Operation and output payload.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff <= q_head;
      end
      if (emit) begin
         out_ff <= out_in;
      end
   end

   `JSAN_ASSERT_ALWAYS(a_pass_one_step, clock, reset, !(cur_valid_ff && (cur_ff.kind == OP_PASS)) || (step_ff == '0), "pass operation advanced past its single beat")
   `JSAN_ASSERT_NEXT(a_load_restart, clock, reset, q_pop, cur_valid_ff && (step_ff == '0), "loaded operation does not start at its first beat")

endmodule

`default_nettype wire

[tb/json_string_utf8_sanitizer_tb.sv]
// Self-checking testbench for the JSON string UTF-8 sanitizer.
// It predicts every output byte, escape and flag, and compares each popped beat with it.
// Depends on jsan_pkg and the json_string_utf8_sanitizer top level.
`default_nettype none

module json_string_utf8_sanitizer_tb;
   import jsan_pkg::*;

   localparam logic [7:0] HEX_A    = 8'h41;
   localparam logic [7:0] CHAR_A   = 8'h61;
   localparam int         RUN_LIMIT = 2_000_000;
   localparam int         SETTLE_CYCLES = 20;

   logic    clock;
   logic    reset;
   logic    push;
   logic    full;
   req_type req_data;
   logic    empty;
   logic    pop;
   rsp_type rsp_data;

   // Expected output bytes, oldest first.
   rsp_type pending_bytes[$];
   rsp_type step_bytes[$];

   // Predictor state.
   bit         str_open;
   bit         escape_next;
   bit         replaced_flag;
   logic [7:0] lead_byte;
   int         held_n;
   logic [7:0] tail_bytes[3];

   int error_count;
   int bytes_sent;
   bit sender_idles;
   bit receiver_idles;

   json_string_utf8_sanitizer dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs.
   initial begin
      #RUN_LIMIT;
      $display("TB_ERROR");
      $finish;
   end

   // Sequence length that a lead byte announces; zero for an unknown lead.
   function automatic int lead_len(logic [7:0] b);
      if (b < 8'h80) return 1;
      if ((b & MASK_2) == LEAD_2) return 2;
      if ((b & MASK_3) == LEAD_3) return 3;
      if ((b & MASK_4) == LEAD_4) return 4;
      return 0;
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return CHAR_0 + {4'h0, n};
      return HEX_A + {4'h0, n} - 8'd10;
   endfunction

   function automatic void emit(logic [7:0] b);
      rsp_type r;
      r.out_byte     = b;
      r.out_last     = 1'b0;
      r.any_replaced = replaced_flag;
      step_bytes.push_back(r);
   endfunction

   function automatic void emit_escape(logic [7:0] b);
      replaced_flag = 1'b1;
      emit(BACKSLASH);
      emit(CHAR_U);
      emit(CHAR_0);
      emit(CHAR_0);
      emit(hex_char(b[7:4]));
      emit(hex_char(b[3:0]));
   endfunction

   // Escape the held lead and every held continuation byte.
   function automatic void flush_held();
      if (held_n == 0) return;
      emit_escape(lead_byte);
      for (int k = 1; k < held_n; k++) emit_escape(tail_bytes[k-1]);
      held_n = 0;
   endfunction

   // A byte seen with nothing held: string tracking, then UTF-8 lead handling.
   function automatic void take_fresh(logic [7:0] b);
      int len;
      if (!str_open) begin
         if (b == QUOTE) str_open = 1'b1;
         emit(b);
         return;
      end
      if (escape_next) begin
         escape_next = 1'b0;
         emit(b);
         return;
      end
      if (b == BACKSLASH) begin
         escape_next = 1'b1;
         emit(b);
         return;
      end
      if (b == QUOTE) begin
         str_open = 1'b0;
         emit(b);
         return;
      end
      len = lead_len(b);
      if (len == 1) emit(b);
      else if (len == 0) emit_escape(b);
      else begin
         lead_byte = b;
         held_n    = 1;
      end
   endfunction

   // Work out every output byte that one accepted input beat causes.
   function automatic void sanitize_byte(req_type item);
      logic [7:0] b;
      rsp_type    tail;
      b = item.data_byte;
      step_bytes.delete();
      if (held_n > 0) begin
         if ((b & CONT_MASK) == CONT_PAT) begin
            tail_bytes[held_n-1] = b;
            held_n++;
            if (held_n == lead_len(lead_byte)) begin
               emit(lead_byte);
               for (int k = 1; k < held_n; k++) emit(tail_bytes[k-1]);
               held_n = 0;
            end
         end else begin
            flush_held();
            take_fresh(b);
         end
      end else begin
         take_fresh(b);
      end
      if (item.end_of_buffer) begin
         flush_held();
         if (step_bytes.size() > 0) begin
            tail          = step_bytes.pop_back();
            tail.out_last = 1'b1;
            step_bytes.push_back(tail);
         end
         str_open      = 1'b0;
         escape_next   = 1'b0;
         replaced_flag = 1'b0;
      end
      foreach (step_bytes[i]) pending_bytes.push_back(step_bytes[i]);
   endfunction

   // Send one beat, with an optional idle burst first, and predict its output.
   task automatic send_byte(input logic [7:0] b, input logic eob);
      req_type item;
      item.data_byte     = b;
      item.end_of_buffer = eob;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (full);
      sanitize_byte(item);
      bytes_sent++;
   endtask

   task automatic wait_drained();
      push <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] cont_byte();
      return {2'b10, 6'($urandom)};
   endfunction

   function automatic logic [7:0] lead_for(int len);
      case (len)
         2:       return {3'b110, 5'($urandom)};
         3:       return {4'b1110, 4'($urandom)};
         default: return {5'b11110, 3'($urandom)};
      endcase
   endfunction

   // One buffer holding a string with random content, mostly well formed.
   task automatic send_random_buffer();
      int         n_elems;
      int         len;
      logic [7:0] b;
      repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(QUOTE, 1'b0);
      n_elems = $urandom_range(1, 6);
      for (int e = 0; e < n_elems; e++) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               b = 8'($urandom_range(8'h20, 8'h7E));
               if (b == QUOTE || b == BACKSLASH) b = CHAR_A;
               send_byte(b, 1'b0);
            end
            2, 3, 4: begin
               len = $urandom_range(2, 4);
               send_byte(lead_for(len), 1'b0);
               repeat (len - 1) send_byte(cont_byte(), 1'b0);
            end
            5: begin
               send_byte(BACKSLASH, 1'b0);
               send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            6: begin
               // Sequence cut short by an arbitrary byte.
               len = $urandom_range(2, 4);
               send_byte(lead_for(len), 1'b0);
               repeat ($urandom_range(0, len - 2)) send_byte(cont_byte(), 1'b0);
               send_byte(8'($urandom_range(0, 255)), 1'b0);
            end
            7: begin
               if ($urandom_range(0, 1)) send_byte(cont_byte(), 1'b0);
               else send_byte({5'b11111, 3'($urandom)}, 1'b0);
            end
            default: send_byte(8'($urandom_range(0, 255)), 1'b0);
         endcase
      end
      // Usually close the string; sometimes end the buffer inside a sequence.
      if ($urandom_range(0, 7) == 0) begin
         len = $urandom_range(3, 4);
         send_byte(lead_for(len), 1'b0);
         send_byte(cont_byte(), 1'b1);
      end else begin
         send_byte(QUOTE, 1'b1);
      end
   endtask

   task automatic run_buffers(input int until_count, input bit allow_idle);
      bit calm;
      while (bytes_sent < until_count) begin
         calm           = !allow_idle || ($urandom_range(0, 3) == 0);
         sender_idles   = !calm;
         receiver_idles = !calm;
         send_random_buffer();
      end
   endtask

   // Bytes outside any string pass unchanged, including a backslash.
   task automatic test_outside_string();
      send_byte(8'h00, 1'b0);
      send_byte(BACKSLASH, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   // Complete two, three and four byte sequences pass through.
   task automatic test_valid_sequences();
      send_byte(QUOTE, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(8'hA9, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'hAC, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'h80, 1'b0);
   endtask

   // Unknown leads and broken sequences become escapes; a quote still closes.
   task automatic test_invalid_bytes();
      send_byte(8'h80, 1'b0);
      send_byte(8'hF8, 1'b0);
      send_byte(8'hE2, 1'b0);
      send_byte(8'h82, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'hC3, 1'b0);
      send_byte(QUOTE, 1'b0);
   endtask

   // A backslash inside a string lets the next byte pass, even a quote or 0xFF.
   task automatic test_escaped_characters();
      send_byte(QUOTE, 1'b0);
      send_byte(BACKSLASH, 1'b0);
      send_byte(QUOTE, 1'b0);
      send_byte(BACKSLASH, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(QUOTE, 1'b1);
   endtask

   // Three held bytes broken by an unknown lead at the end of the buffer.
   task automatic test_max_expansion();
      send_byte(QUOTE, 1'b0);
      send_byte(8'hF0, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'h98, 1'b0);
      send_byte(8'hFF, 1'b1);
   endtask

   task automatic test_random_buffers();
      run_buffers(140, 1'b1);
   endtask

   // Let the block run dry, then start again from a quiet state.
   task automatic test_restart_after_drain();
      wait_drained();
      run_buffers(190, 1'b1);
   endtask

   task automatic test_random_noise();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      repeat (30) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
      send_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic test_full_rate();
      run_buffers(250, 1'b0);
   endtask

   // Result side: check each popped beat and pick the next pop with stall bursts.
   initial begin
      int stall_left;
      rsp_type want;
      stall_left = 0;
      pop <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            pop <= 1'b0;
         end else begin
            if (pop && !empty) begin
               if (pending_bytes.size() == 0) begin
                  $error("result beat with no expected byte: out_byte %h", rsp_data.out_byte);
                  error_count++;
               end else begin
                  want = pending_bytes.pop_front();
                  if (rsp_data.out_byte !== want.out_byte) begin
                     $error("out_byte: expected %h, got %h", want.out_byte, rsp_data.out_byte);
                     error_count++;
                  end
                  if (rsp_data.out_last !== want.out_last) begin
                     $error("out_last: expected %b, got %b", want.out_last, rsp_data.out_last);
                     error_count++;
                  end
                  if (rsp_data.any_replaced !== want.any_replaced) begin
                     $error("any_replaced: expected %b, got %b",
                            want.any_replaced, rsp_data.any_replaced);
                     error_count++;
                  end
               end
            end
            if (stall_left > 0) begin
               pop <= 1'b0;
               stall_left--;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
               pop <= 1'b0;
               stall_left = $urandom_range(1, 7) - 1;
            end else begin
               pop <= 1'b1;
            end
         end
      end
   end

   // Reset, run every test in turn, then wait for the output to settle.
   initial begin
      error_count    = 0;
      bytes_sent     = 0;
      held_n         = 0;
      str_open       = 1'b0;
      escape_next    = 1'b0;
      replaced_flag  = 1'b0;
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      reset    <= 1'b1;
      push     <= 1'b0;
      req_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      test_outside_string();
      test_valid_sequences();
      test_invalid_bytes();
      test_escaped_characters();
      test_max_expansion();
      test_random_buffers();
      test_restart_after_drain();
      test_random_noise();
      test_full_rate();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
